FILE: rtl/sidtoa_pkg.sv
package sidtoa_pkg;

    // Input word: two's complement wide enough for signed and unsigned 32-bit
    localparam int VALUE_W    = 33;
    localparam int S_TDATA_W  = ((VALUE_W + 7) / 8) * 8;

    // Decimal digits kept by the converter; larger magnitudes saturate to all nines
    localparam int MAX_DIGITS = 10;
    localparam int BCD_W      = MAX_DIGITS * 4;
    localparam int CNT_W      = $clog2(VALUE_W + 1);
    localparam int REM_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [3:0] DIGIT_NINE  = 4'd9;

    typedef struct packed {
        logic load;
        logic conv;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } sidtoa_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic rem_one;
        logic neg;
        logic out_free;
    } sidtoa_status_t;

endpackage

FILE: rtl/sidtoa_ctrl.sv
module sidtoa_ctrl
    import sidtoa_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  sidtoa_status_t status,
    output sidtoa_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (status.conv_done) begin
                    state_next = ST_SKIP;
                end else begin
                    cmd.conv = 1'b1;
                end
            end
            ST_SKIP: begin
                // strip leading zeros, always keep the units digit
                if (status.top_zero && !status.rem_one) begin
                    cmd.skip = 1'b1;
                end else if (status.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.rem_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_cmd_onehot0: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.conv, cmd.skip, cmd.emit_sign, cmd.emit_digit}))
        else $error("more than one datapath command at once");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_sign || cmd.emit_digit) |-> status.out_free)
        else $error("item written into a full output register");

    a_conv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.conv |-> !status.conv_done)
        else $error("conversion shifted past the input width");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_CONV))
        else $error("load did not start a conversion");
`endif

endmodule

FILE: rtl/sidtoa_dp.sv
module sidtoa_dp
    import sidtoa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [VALUE_W-1:0] value,
    input  sidtoa_cmd_t        cmd,
    output sidtoa_status_t     status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               out_last
);

    logic [VALUE_W-1:0] mag_reg,   mag_next;
    logic [BCD_W-1:0]   bcd_reg,   bcd_next;
    logic               neg_reg,   neg_next;
    logic               sat_reg,   sat_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [REM_W-1:0]   rem_reg,   rem_next;
    logic               ovalid_reg, ovalid_next;
    logic [7:0]         ochar_reg, ochar_next;
    logic               olast_reg, olast_next;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         digit_top;

    // add-3 correction on every BCD digit before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign digit_top = sat_reg ? DIGIT_NINE : bcd_reg[BCD_W-1 -: 4];

    assign status.conv_done = (cnt_reg == '0);
    assign status.top_zero  = (digit_top == 4'd0);
    assign status.rem_one   = (rem_reg == REM_W'(1));
    assign status.neg       = neg_reg;
    assign status.out_free  = !ovalid_reg || out_ready;

    always_comb begin
        mag_next    = mag_reg;
        bcd_next    = bcd_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !out_ready;

        if (cmd.load) begin
            neg_next = value[VALUE_W-1];
            // 33-bit negate: the most negative input still gives its exact magnitude
            mag_next = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
            bcd_next = '0;
            sat_next = 1'b0;
            cnt_next = CNT_W'(VALUE_W);
            rem_next = REM_W'(MAX_DIGITS);
        end

        if (cmd.conv) begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            sat_next = sat_reg | bcd_adj[BCD_W-1];
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (cmd.skip || cmd.emit_digit) begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
            rem_next = rem_reg - REM_W'(1);
        end

        if (cmd.emit_sign) begin
            ochar_next  = ASCII_MINUS;
            olast_next  = 1'b0;
            ovalid_next = 1'b1;
        end

        if (cmd.emit_digit) begin
            ochar_next  = ASCII_ZERO + {4'd0, digit_top};
            olast_next  = (rem_reg == REM_W'(1));
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        sat_reg   <= sat_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;

`ifndef SYNTHESIS
    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit && status.rem_one |=> ovalid_reg && olast_reg)
        else $error("final digit not flagged last");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit |-> (digit_top <= DIGIT_NINE))
        else $error("BCD digit out of range");

    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.skip || cmd.emit_digit) |-> (rem_reg != '0))
        else $error("digit counter underflow");
`endif

endmodule

FILE: rtl/signed_int_to_decimal_ascii_core.sv
// Integer to decimal ASCII text. Each input item is a 33-bit two's complement
// integer (covers both signed and unsigned 32-bit values); the block returns
// its decimal text as a run of one-byte items: '-' for a negative value, then
// the digits most significant first without leading zeros ("0" for zero), with
// m_tlast set on the final character. Steps per item: the item is accepted,
// the shift-and-add-3 binary-to-BCD conversion runs (one input bit per
// cycle through the shared BCD register, plus a done check), a leading-zero
// pass strips zeros (up to 9) and is then left, and the sign of a negative
// value and then the digits are sent while the output side is ready.
// Stripped zeros and digits always add up to ten. s_tready is high only
// while the block is idle. The result channel has its own output register,
// so the last character can wait on m_tready while the next integer is
// already accepted. Magnitudes beyond MAX_DIGITS digits print as all
// nines; at ten digits this cannot occur.
module signed_int_to_decimal_ascii_core
    import sidtoa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input item
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [32:0] value, rest zero
    // result item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] char_byte
    output logic                 m_tlast    // last
);

    sidtoa_cmd_t    cmd;
    sidtoa_status_t status;

    sidtoa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // padding bits of s_tdata above the value are ignored
    sidtoa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .value     (s_tdata[VALUE_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
